// ===== rtl/osp_pkg.sv =====
// Shared types and constants for the ordered set engine.
package osp_pkg;

  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_KEY_WIDTH = 32;

  localparam int OP_W        = 3;
  localparam int KEY_PORT_W  = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_EXISTS = 3'd2,
    OP_SUCC   = 3'd3,
    OP_PRED   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

  // Control part of the search token that walks the chain
  typedef struct packed {
    logic active;
    op_t  op;
    logic hit;
    logic free_found;
    logic have;
  } tok_ctl_t;

  // Store update issued once a search has finished
  typedef struct packed {
    logic set;
    logic clr;
  } wr_cmd_t;

endpackage

// ===== rtl/osp_cell.sv =====
// One slot of the set: stored key and valid bit, plus one stage of the search token path.
module osp_cell import osp_pkg::*; #(
  parameter int KEY_WIDTH = DEF_KEY_WIDTH,
  parameter int IDX_W     = 6,
  parameter int INDEX     = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tok_ctl_t                    in_ctl,
  input  logic signed [KEY_WIDTH-1:0] in_key,
  input  logic        [IDX_W-1:0]     in_hit_idx,
  input  logic        [IDX_W-1:0]     in_free_idx,
  input  logic signed [KEY_WIDTH-1:0] in_best,
  output tok_ctl_t                    out_ctl,
  output logic signed [KEY_WIDTH-1:0] out_key,
  output logic        [IDX_W-1:0]     out_hit_idx,
  output logic        [IDX_W-1:0]     out_free_idx,
  output logic signed [KEY_WIDTH-1:0] out_best,
  input  wr_cmd_t                     wr,
  input  logic        [IDX_W-1:0]     wr_idx,
  input  logic signed [KEY_WIDTH-1:0] wr_key
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [KEY_WIDTH-1:0] slot_key;
  logic                        slot_valid;

  tok_ctl_t                    ctl_next;
  logic        [IDX_W-1:0]     hit_idx_next;
  logic        [IDX_W-1:0]     free_idx_next;
  logic signed [KEY_WIDTH-1:0] best_next;
  logic                        match;
  logic                        above;
  logic                        below;

  assign match = slot_valid && (slot_key == in_key);
  assign above = slot_valid && (slot_key > in_key);
  assign below = slot_valid && (slot_key < in_key);

  always_comb begin
    ctl_next      = in_ctl;
    hit_idx_next  = in_hit_idx;
    free_idx_next = in_free_idx;
    best_next     = in_best;
    if (in_ctl.active) begin
      if (match) begin
        ctl_next.hit = 1'b1;
        hit_idx_next = MY_IDX;
      end
      // first empty slot along the chain is the lowest free one
      if (!slot_valid && !in_ctl.free_found) begin
        ctl_next.free_found = 1'b1;
        free_idx_next       = MY_IDX;
      end
      case (in_ctl.op)
        OP_SUCC: begin
          if (above && (!in_ctl.have || slot_key < in_best)) begin
            ctl_next.have = 1'b1;
            best_next     = slot_key;
          end
        end
        OP_PRED: begin
          if (below && (!in_ctl.have || slot_key > in_best)) begin
            ctl_next.have = 1'b1;
            best_next     = slot_key;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl    <= '0;
      slot_valid <= 1'b0;
    end else begin
      out_ctl <= ctl_next;
      if (wr.set && wr_idx == MY_IDX) begin
        slot_valid <= 1'b1;
      end else if (wr.clr && wr_idx == MY_IDX) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_key      <= in_key;
    out_hit_idx  <= hit_idx_next;
    out_free_idx <= free_idx_next;
    out_best     <= best_next;
    if (wr.set && wr_idx == MY_IDX) begin
      slot_key <= wr_key;
    end
  end

endmodule

// ===== rtl/ordered_set_successor_predecessor_top.sv =====
// Top level of the ordered set engine: request intake, chain of slot cells, result register.
//
//  channel | dir | fields (lsb first)                          | accepted when
//  s_axis  | in  | op[2:0], key[34:3], zero pad                | tvalid & tready
//  m_axis  | out | found[0], neighbor[32:1], full_res[33], pad | tvalid & tready
//
// A request token walks the cell chain one slot per cycle; a new request is
// taken only once the previous result has been loaded into the output register.
// The result passes the injection register, the cell chain, the done register and the output register.
// Reset clears all valid bits at once; the block takes requests straight after.
// A stalled result sits in the output register while the next request is searched.
module ordered_set_successor_predecessor_top import osp_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // op[2:0], key[34:3]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // found[0], neighbor[32:1], full_res[33]
);

  localparam int IDX_W = $clog2(CAPACITY);

  state_t state;
  state_t state_next;

  logic                         in_take;
  logic signed [KEY_PORT_W-1:0] in_key_raw;
  logic signed [KEY_WIDTH-1:0]  in_key;
  tok_ctl_t                     inject_ctl;

  tok_ctl_t                    link_ctl      [CAPACITY+1];
  logic signed [KEY_WIDTH-1:0] link_key      [CAPACITY+1];
  logic        [IDX_W-1:0]     link_hit_idx  [CAPACITY+1];
  logic        [IDX_W-1:0]     link_free_idx [CAPACITY+1];
  logic signed [KEY_WIDTH-1:0] link_best     [CAPACITY+1];

  tok_ctl_t                    done_ctl;
  logic signed [KEY_WIDTH-1:0] done_key;
  logic        [IDX_W-1:0]     done_hit_idx;
  logic        [IDX_W-1:0]     done_free_idx;
  logic signed [KEY_WIDTH-1:0] done_best;
  logic signed [KEY_PORT_W-1:0] done_best_port;

  wr_cmd_t          wr;
  logic [IDX_W-1:0] wr_idx;

  logic                  res_load;
  logic                  res_found;
  logic [KEY_PORT_W-1:0] res_neighbor;
  logic                  res_full;

  logic                  found_q;
  logic [KEY_PORT_W-1:0] neighbor_q;
  logic                  full_q;

  assign in_key_raw = s_axis_tdata[OP_W +: KEY_PORT_W];

  generate
    if (KEY_WIDTH <= KEY_PORT_W) begin : g_key_narrow
      assign in_key = in_key_raw[KEY_WIDTH-1:0];
    end else begin : g_key_wide
      assign in_key = {{(KEY_WIDTH-KEY_PORT_W){in_key_raw[KEY_PORT_W-1]}}, in_key_raw};
    end
    if (KEY_WIDTH >= KEY_PORT_W) begin : g_out_trunc
      assign done_best_port = done_best[KEY_PORT_W-1:0];
    end else begin : g_out_ext
      assign done_best_port = {{(KEY_PORT_W-KEY_WIDTH){done_best[KEY_WIDTH-1]}}, done_best};
    end
  endgenerate

  always_comb begin
    inject_ctl        = '0;
    inject_ctl.active = in_take;
    inject_ctl.op     = op_t'(s_axis_tdata[OP_W-1:0]);
  end

  // Token injection register feeds the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      link_ctl[0] <= '0;
    end else begin
      link_ctl[0] <= inject_ctl;
    end
  end

  always_ff @(posedge clk) begin
    link_key[0] <= in_key;
  end

  assign link_hit_idx[0]  = '0;
  assign link_free_idx[0] = '0;
  assign link_best[0]     = '0;

  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      osp_cell #(
        .KEY_WIDTH (KEY_WIDTH),
        .IDX_W     (IDX_W),
        .INDEX     (i)
      ) u_cell (
        .clk          (clk),
        .rst          (rst),
        .in_ctl       (link_ctl[i]),
        .in_key       (link_key[i]),
        .in_hit_idx   (link_hit_idx[i]),
        .in_free_idx  (link_free_idx[i]),
        .in_best      (link_best[i]),
        .out_ctl      (link_ctl[i+1]),
        .out_key      (link_key[i+1]),
        .out_hit_idx  (link_hit_idx[i+1]),
        .out_free_idx (link_free_idx[i+1]),
        .out_best     (link_best[i+1]),
        .wr           (wr),
        .wr_idx       (wr_idx),
        .wr_key       (done_key)
      );
    end
  endgenerate

  // Hold the finished token until the result register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      done_ctl <= '0;
    end else if (state == ST_SCAN && link_ctl[CAPACITY].active) begin
      done_ctl <= link_ctl[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && link_ctl[CAPACITY].active) begin
      done_key      <= link_key[CAPACITY];
      done_hit_idx  <= link_hit_idx[CAPACITY];
      done_free_idx <= link_free_idx[CAPACITY];
      done_best     <= link_best[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    in_take       = 1'b0;
    res_load      = 1'b0;
    res_found     = 1'b0;
    res_neighbor  = '0;
    res_full      = 1'b0;
    wr            = '0;
    wr_idx        = done_free_idx;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        in_take       = s_axis_tvalid;
        if (s_axis_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (link_ctl[CAPACITY].active) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
          case (done_ctl.op)
            OP_INSERT: begin
              if (done_ctl.hit) begin
                res_found = 1'b1;
              end else if (done_ctl.free_found) begin
                res_found = 1'b1;
                wr.set    = 1'b1;
              end else begin
                res_full = 1'b1;
              end
            end
            OP_DELETE: begin
              if (done_ctl.hit) begin
                res_found = 1'b1;
                wr.clr    = 1'b1;
                wr_idx    = done_hit_idx;
              end
            end
            OP_EXISTS: begin
              res_found = done_ctl.hit;
            end
            OP_SUCC, OP_PRED: begin
              res_found = done_ctl.have;
              if (done_ctl.have) begin
                res_neighbor = done_best_port;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      found_q    <= res_found;
      neighbor_q <= res_neighbor;
      full_q     <= res_full;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W-KEY_PORT_W-2)'(0), full_q, neighbor_q, found_q};

endmodule

// ===== rtl/osp_checker.sv =====
// Port-level assertions for the ordered set engine, bound to the top level.
module osp_checker import osp_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time: intake closes after an accepted item
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while a search is in flight");

  // a dropped insert never also reports success
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[33]))
    else $error("found and full_res both set");

  // a non-zero neighbour comes only with found
  a_nbr_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[32:1] != 32'd0) |-> m_axis_tdata[0])
    else $error("neighbour reported without found");

endmodule

bind ordered_set_successor_predecessor_top osp_checker u_osp_checker (.*);
